[hw/rtl/cst_pkg.sv]
`timescale 1ns / 1ps

package cst_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Word fields
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int MCOUNT_W = 7;

    // Operation codes (any other code acts as a look up)
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

    // Sequencer states
    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [STATE_W-1:0] ST_SCAN  = 2'd1;
    localparam logic [STATE_W-1:0] ST_SHIFT = 2'd2;

endpackage

[hw/rtl/cst_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read
module cst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/compacting_set_table.sv]
`timescale 1ns / 1ps

// Channel   Handshake                 Ports
// -------   -----------------------   ---------------------------------------
// command   start & !busy at edge     opcode, value
// result    done high for one cycle   was_present, member_count, dropped_full
//
// Operation: a look up, insert or remove first runs a linear search that reads entries
// from index 0 up and stops at a match or at entry count - 1; an empty table
// answers without a search. A remove that hits position p then shifts the
// count - p - 1 later entries down one place, one RAM read and one write each.
// Reset clears the count, the state and done only; the entry RAM is left unwritten, no clearing pass.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module compacting_set_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cst_pkg::OPCODE_W-1:0]  opcode,
    input  logic signed [cst_pkg::VALUE_W-1:0] value,
    output logic                          busy,
    output logic                          done,
    output logic                          was_present,
    output logic [cst_pkg::MCOUNT_W-1:0]  member_count,
    output logic                          dropped_full
);

    import cst_pkg::*;

    logic [STATE_W-1:0]  state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                done_reg;
    logic                present_reg;
    logic                dropped_reg;
    logic [MCOUNT_W-1:0] mcount_reg;

    // RAM port signals
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [VALUE_W-1:0]  wdata;
    logic [IDX_W-1:0]    raddr;
    logic [VALUE_W-1:0]  rdata;

    // Decision and result signals
    logic                accept;
    logic                decide;
    logic                dec_present;
    logic [IDX_W-1:0]    dec_pos;
    logic [OPCODE_W-1:0] act_op;
    logic [VALUE_W-1:0]  act_value;
    logic                finish;
    logic                res_present;
    logic                res_dropped;
    logic [IDX_W-1:0]    last_idx;

    assign accept   = start && (state_reg == ST_IDLE);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    cst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Sequencer: search, then append on insert or shift later entries down on remove
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = value_reg;
        raddr       = '0;
        decide      = 1'b0;
        dec_present = 1'b0;
        dec_pos     = idx_reg;
        act_op      = op_reg;
        act_value   = value_reg;
        finish      = 1'b0;
        res_present = 1'b0;
        res_dropped = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_op    = opcode;
                    act_value = $unsigned(value);
                    if (count_reg == '0)
                    begin
                        // empty table: absent straight away
                        decide = 1'b1;
                    end
                    else
                    begin
                        raddr      = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rdata == value_reg)
                begin
                    decide      = 1'b1;
                    dec_present = 1'b1;
                    dec_pos     = idx_reg;
                end
                else if (idx_reg == last_idx)
                begin
                    decide = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    raddr    = idx_next;
                end
            end
            ST_SHIFT:
            begin
                // entry at idx moves down one place
                we    = 1'b1;
                waddr = idx_reg - IDX_W'(1);
                wdata = rdata;
                if (idx_reg == last_idx)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    finish      = 1'b1;
                    res_present = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    raddr    = idx_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Act on the search outcome
        if (decide)
        begin
            finish      = 1'b1;
            res_present = dec_present;
            state_next  = ST_IDLE;
            if ((act_op == OP_INSERT) && !dec_present)
            begin
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    res_dropped = 1'b1;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = IDX_W'(count_reg);
                    wdata      = act_value;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else if ((act_op == OP_REMOVE) && dec_present)
            begin
                if (dec_pos == last_idx)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    finish     = 1'b0;
                    idx_next   = dec_pos + IDX_W'(1);
                    raddr      = idx_next;
                    state_next = ST_SHIFT;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= finish;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            op_reg    <= opcode;
            value_reg <= $unsigned(value);
        end
        if (finish)
        begin
            present_reg <= res_present;
            dropped_reg <= res_dropped;
            mcount_reg  <= MCOUNT_W'(count_next);
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign was_present  = present_reg;
    assign member_count = mcount_reg;
    assign dropped_full = dropped_reg;

endmodule
